[sv/bbds_pkg.sv]
package bbds_pkg;

    // Item kinds carried in the slave-side tuser
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_BOLUS   = 3'd2;
    localparam logic [2:0] OP_REVERSE = 3'd3;
    localparam logic [2:0] OP_PROFILE = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MIN_DOSE = 1'b0;
    localparam logic CFG_STEPS_PU = 1'b1;

    localparam int HOURS_DEF = 24;

    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [13:0] REVERSE_AMOUNT = 14'd10;
    localparam logic [13:0] HOUR_MAX       = 14'h3FFF;
    localparam logic [18:0] STEPS_MAX      = 19'h7FFFF;

    // floor(x / 100) for x below 2^27: (x * STEPS_RECIP) >> STEPS_SHIFT
    localparam logic [25:0] STEPS_RECIP = 26'd42949673;
    localparam int          STEPS_SHIFT = 32;

    // Shared divider geometry
    localparam int DIV_DW = 14;   // widest dividend: profile target less hour amount
    localparam int DIV_VW = 14;   // widest divisor
    localparam int DIV_CW = 5;    // bit counter

    localparam logic [DIV_CW-1:0] NB_DUE   = 5'd14;
    localparam logic [DIV_CW-1:0] NB_IVL   = 5'd12;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] nbits;     // quotient bits to develop
        logic [DIV_DW-1:0] dividend;  // left aligned to nbits
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quo;
    } t_div_rsp;

endpackage

[sv/bbds_div.sv]
module bbds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbds_pkg::t_div_req i_req,
    output bbds_pkg::t_div_rsp o_rsp
);
    import bbds_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_dvs;

    logic [DIV_VW:0] sh;
    logic [DIV_VW:0] diff;
    logic            ge;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        sh   = {r_rem, r_quo[DIV_DW-1]};
        diff = sh - {1'b0, r_dvs};
        ge   = (sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.nbits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_DW-2:0], ge};
            r_rem <= ge ? diff[DIV_VW-1:0] : sh[DIV_VW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[sv/basal_bolus_dose_scheduler.sv]
// Basal/bolus dose scheduler. Amounts are hundredths of a unit of drug.
// Slave side (s_axis_*): one request per item; tuser carries the item kind
// (tick, start hour, bolus, reverse, profile write), tdata the hour, minute,
// second and amount. Master side (m_axis_*): exactly one result per request
// with motor direction, half steps, basal flag, hour and total amounts and
// the current basal interval.
// Configuration: i_cfg_we writes min_dose (index 0) or steps_per_unit
// (index 1); write only while no request is in flight.
// Throughput: one request at a time. A tick that fires nothing, a profile
// write or an unused kind passes through lookup to the result; the next
// request is taken once the result is loaded. Anything that moves the motor
// multiplies, then divides by 100 through a reciprocal multiply.
// Start hour runs a 14-bit and a 12-bit division through the bit-serial
// divider, the second skipped when no doses are due, and sets the rate.
// Reset clears all counters and the profile valid bits, so every profile
// entry reads as zero until written; no clearing pass is needed.
// A stalled result waits in the output register; the next request is still
// taken and worked, then holds in its last step with s_axis_tready low until
// the register frees.
module basal_bolus_dose_scheduler #(
    parameter int HOURS_PER_DAY = bbds_pkg::HOURS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] hour, [10:5] minute, [16:11] second, [30:17] amount, [31] zero
    input  logic [31:0] s_axis_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] direction, [19:1] steps, [20] basal_fired, [34:21] delivered_hour,
    // [66:35] delivered_total, [78:67] interval_now, [79] zero
    output logic [79:0] m_axis_tdata
);
    import bbds_pkg::*;

    localparam int AW = (HOURS_PER_DAY > 1) ? $clog2(HOURS_PER_DAY) : 1;
    localparam logic [6:0] HOURS_W = 7'(HOURS_PER_DAY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SDIV = 3'd3;
    localparam logic [2:0] S_DIV1 = 3'd4;
    localparam logic [2:0] S_DIV2 = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // Input fields
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [13:0] in_amount;
    logic [AW+4:0] hour_ext;
    logic [AW-1:0] in_idx;
    logic        in_range;
    logic        accept;

    assign in_hour   = s_axis_tdata[4:0];
    assign in_minute = s_axis_tdata[10:5];
    assign in_second = s_axis_tdata[16:11];
    assign in_amount = s_axis_tdata[30:17];
    assign hour_ext  = {{AW{1'b0}}, in_hour};
    assign in_idx    = hour_ext[AW-1:0];
    assign in_range  = ({2'b00, in_hour} < HOURS_W);
    assign accept    = s_axis_tvalid && s_axis_tready;

    // Control and state
    logic [2:0]  r_state;
    logic [9:0]  r_min_dose;
    logic [12:0] r_spu;
    logic [11:0] r_count;
    logic [11:0] r_interval;
    logic [13:0] r_hd;
    logic [31:0] r_total;
    logic [HOURS_PER_DAY-1:0] r_vld;
    logic        r_m_valid;

    // Item payload and result fields
    logic [2:0]  r_op;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic [13:0] r_amount;
    logic        r_hit;
    logic [13:0] r_rdata;
    logic [13:0] r_amt;
    logic [26:0] r_prod;
    logic [11:0] r_secs_left;
    logic        r_dir;
    logic        r_fired;
    logic [18:0] r_steps;
    logic [79:0] r_m_data;

    // Profile store: synchronous single port, registered read
    logic [13:0] mem [HOURS_PER_DAY];

    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            if (s_axis_tuser == OP_PROFILE) begin
                mem[in_idx] <= in_amount;
            end
            r_rdata <= mem[in_idx];
        end
    end

    // Shared divider
    t_div_req div_req;
    t_div_rsp div_rsp;

    bbds_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Combinational helpers for the lookup, multiply and divide steps
    logic [13:0] target;
    logic [11:0] cnt_inc;
    logic [11:0] elapsed;
    logic [14:0] hd_sum;
    logic [32:0] tot_min;
    logic [32:0] tot_amt;
    logic [26:0] product;
    logic [52:0] recip;
    logic [20:0] step_quo;
    logic [13:0] due;

    always_comb begin
        target   = r_hit ? r_rdata : 14'd0;
        cnt_inc  = r_count + 12'd1;
        elapsed  = 12'(r_minute) * 12'(SECS_PER_MIN) + 12'(r_second);
        hd_sum   = {1'b0, r_hd} + 15'(r_min_dose);
        tot_min  = {1'b0, r_total} + 33'(r_min_dose);
        tot_amt  = {1'b0, r_total} + 33'(r_amount);
        product  = 27'(r_spu) * 27'(r_amt);
        recip    = 53'(r_prod) * 53'(STEPS_RECIP);
        step_quo = recip[STEPS_SHIFT+20:STEPS_SHIFT];
        due      = div_rsp.quo;
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.nbits    = NB_DUE;
        div_req.dividend = target - r_hd;
        div_req.divisor  = 14'(r_min_dose);
        unique case (r_state)
            S_LOOK: begin
                div_req.start = (r_op == OP_START) && (r_min_dose != 10'd0)
                                && (target > r_hd);
            end
            S_DIV1: begin
                div_req.start    = div_rsp.done && (due != 14'd0);
                div_req.nbits    = NB_IVL;
                div_req.dividend = {r_secs_left, 2'b00};
                div_req.divisor  = due;
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Control state, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_min_dose <= 10'd10;
            r_spu      <= 13'd100;
            r_count    <= '0;
            r_interval <= '0;
            r_hd       <= '0;
            r_total    <= '0;
            r_vld      <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_DOSE: r_min_dose <= i_cfg_wdata[9:0];
                    CFG_STEPS_PU: r_spu      <= i_cfg_wdata;
                endcase
            end
            // Load a finished result when the register is free, else drop a taken one
            if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                        if (s_axis_tuser == OP_PROFILE && in_range) begin
                            r_vld[in_idx] <= 1'b1;
                        end
                    end
                end
                S_LOOK: begin
                    unique case (r_op)
                        OP_TICK: begin
                            if (r_interval != 12'd0 && cnt_inc == r_interval) begin
                                r_count <= '0;
                                if (r_hd < target) begin
                                    r_hd    <= hd_sum[14] ? HOUR_MAX : hd_sum[13:0];
                                    r_total <= tot_min[32] ? 32'hFFFF_FFFF
                                                           : tot_min[31:0];
                                    r_state <= S_MUL;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else begin
                                r_count <= cnt_inc;
                                r_state <= S_DONE;
                            end
                        end
                        OP_START: begin
                            r_count <= '0;
                            if (div_req.start) begin
                                r_state <= S_DIV1;
                            end else begin
                                r_interval <= '0;
                                r_state    <= S_DONE;
                            end
                        end
                        OP_BOLUS: begin
                            if (r_amount != 14'd0) begin
                                r_total <= tot_amt[32] ? 32'hFFFF_FFFF : tot_amt[31:0];
                                r_state <= S_MUL;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        OP_REVERSE: begin
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_MUL: begin
                    r_state <= S_SDIV;
                end
                S_SDIV: begin
                    r_state <= S_DONE;
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        if (due == 14'd0) begin
                            r_interval <= '0;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_DIV2;
                        end
                    end
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        r_interval <= div_rsp.quo[11:0];
                        r_state    <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_m_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= s_axis_tuser;
            r_minute <= in_minute;
            r_second <= in_second;
            r_amount <= in_amount;
            r_hit    <= in_range && r_vld[in_idx];
            r_dir    <= 1'b0;
            r_fired  <= 1'b0;
            r_steps  <= '0;
        end
        if (r_state == S_LOOK) begin
            r_secs_left <= (elapsed > SECS_PER_HOUR) ? 12'd0 : SECS_PER_HOUR - elapsed;
            if (r_op == OP_TICK) begin
                r_amt   <= 14'(r_min_dose);
                r_fired <= (r_interval != 12'd0) && (cnt_inc == r_interval)
                           && (r_hd < target);
            end else if (r_op == OP_REVERSE) begin
                r_amt <= REVERSE_AMOUNT;
                r_dir <= 1'b1;
            end else begin
                r_amt <= r_amount;
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= product;
        end
        if (r_state == S_SDIV) begin
            r_steps <= (step_quo > 21'(STEPS_MAX)) ? STEPS_MAX : step_quo[18:0];
        end
        if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
            r_m_data <= {1'b0, r_interval, r_total, r_hd, r_fired, r_steps, r_dir};
        end
    end

    // Checks
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK))
        else $error("accepted request did not start lookup");

    a_interval_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_interval <= SECS_PER_HOUR)
        else $error("basal interval beyond one hour");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished with nobody waiting");

    a_start_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && r_op == OP_START) |=> (r_count == 12'd0))
        else $error("start hour left second count nonzero");

endmodule
